@@ hdl/cma_pkg.sv @@
// shared constants and types of the calibrating moving average
package cma_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int DEPTH_DEFAULT = 16;
    localparam int OFFSET_BITS   = 12;
    localparam int AVG_BITS      = 12;
    localparam int FULL_BITS     = 13;
    localparam int S_DATA_BITS   = 16;
    localparam int M_DATA_BITS   = 40;

    typedef enum logic
    {
        KIND_AVERAGE    = 1'b0,
        KIND_CALIBRATED = 1'b1
    } event_kind_t;

endpackage

@@ hdl/calibrating_moving_average_core.sv @@
// top level of the calibrating moving average
// Takes one 12-bit ADC sample per item on the s_ stream and keeps a boxcar
// average over the last DEPTH samples, rounded half up.
// The first DEPTH-1 items give no result; the DEPTH-th item gives a
// calibration-complete result (tuser = 1) carrying the landed level and the
// full level (landed minus full_offset, 13-bit two's complement). Every later
// item gives an average-update result (tuser = 0) with landed and full zero.
// The user must write full_offset on the cfg_ channel while the block is idle;
// the block does not enforce this. Throughput is one item per clock while
// m_tready is high: the ring memory is read one entry ahead and written once
// per item. Each result is registered by the ring and running sum stage, then
// by the reciprocal multiply stage, whose result register drives m_tvalid.
// When m_tready is low the result register holds and s_tready drops once
// both stages are full; with m_tready high s_tready stays high.
// Reset clears the running sum, write position, calibration flag and
// full_offset; the ring needs no clearing pass since unfilled entries are
// taken as zero until calibration completes.
module calibrating_moving_average_core #(
    parameter int DEPTH = cma_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cma_pkg::S_DATA_BITS-1:0]  s_tdata,   // sample[11:0], zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cma_pkg::M_DATA_BITS-1:0]  m_tdata,   // average, landed_level, full_level, pad
    output logic [0:0]                       m_tuser,   // event_kind
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cma_pkg::OFFSET_BITS-1:0]  cfg_data   // full_offset
);

    localparam int SUM_W = cma_pkg::SAMPLE_BITS + $clog2(DEPTH);
    localparam int PAD_W = cma_pkg::M_DATA_BITS - 2 * cma_pkg::AVG_BITS - cma_pkg::FULL_BITS;

    logic [cma_pkg::OFFSET_BITS-1:0] offset_reg;
    logic                            mid_valid;
    logic                            mid_ready;
    cma_pkg::event_kind_t            mid_kind;
    logic [SUM_W-1:0]                mid_sum;
    cma_pkg::event_kind_t            res_kind;
    logic [cma_pkg::AVG_BITS-1:0]    res_average;
    logic [cma_pkg::AVG_BITS-1:0]    res_landed;
    logic [cma_pkg::FULL_BITS-1:0]   res_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    cma_ring #(
        .DEPTH (DEPTH),
        .SUM_W (SUM_W)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata[cma_pkg::SAMPLE_BITS-1:0]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_kind  (mid_kind),
        .out_sum   (mid_sum)
    );

    cma_mean #(
        .DEPTH (DEPTH),
        .SUM_W (SUM_W)
    ) u_mean (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .in_kind      (mid_kind),
        .in_sum       (mid_sum),
        .full_offset  (offset_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (res_kind),
        .average      (res_average),
        .landed_level (res_landed),
        .full_level   (res_full)
    );

    assign m_tdata = {PAD_W'(0), res_full, res_landed, res_average};
    assign m_tuser = res_kind;

    a_cal_avg_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_kind == cma_pkg::KIND_CALIBRATED) |-> (res_average == res_landed))
        else $error("calibration result average differs from landed level");

    a_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_kind == cma_pkg::KIND_AVERAGE) |-> (res_landed == '0 && res_full == '0))
        else $error("average update carries landed or full level");

    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

endmodule

@@ hdl/cma_ring.sv @@
// sample ring, running sum and calibration tracking (first stage)
module cma_ring #(
    parameter int DEPTH = cma_pkg::DEPTH_DEFAULT,
    parameter int SUM_W = cma_pkg::SAMPLE_BITS + $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cma_pkg::SAMPLE_BITS-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cma_pkg::event_kind_t           out_kind,
    output logic [SUM_W-1:0]               out_sum
);

    localparam int PW = $clog2(DEPTH);

    logic [cma_pkg::SAMPLE_BITS-1:0] ring_mem [DEPTH];
    logic [cma_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic [PW-1:0]                   pos_reg;
    logic [PW-1:0]                   pos_next;
    logic                            calibrated_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [SUM_W-1:0]                sum_next;
    logic                            valid_reg;
    cma_pkg::event_kind_t            kind_reg;
    logic [cma_pkg::SAMPLE_BITS-1:0] old_sample;
    logic                            accept;
    logic                            last_fill;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign last_fill = (pos_reg == PW'(DEPTH - 1));
    assign pos_next  = last_fill ? '0 : pos_reg + PW'(1);

    // entries not yet written during the first fill read as zero
    assign old_sample = calibrated_reg ? rd_data_reg : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[pos_reg] <= sample;
            rd_data_reg       <= ring_mem[pos_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            calibrated_reg <= 1'b0;
            sum_reg        <= '0;
            valid_reg      <= 1'b0;
            kind_reg       <= cma_pkg::KIND_AVERAGE;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            valid_reg <= calibrated_reg || last_fill;
            kind_reg  <= calibrated_reg ? cma_pkg::KIND_AVERAGE : cma_pkg::KIND_CALIBRATED;
            if (last_fill)
            begin
                calibrated_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_sum   = sum_reg;

endmodule

@@ hdl/cma_mean.sv @@
// rounded mean by reciprocal multiply and result register (second stage)
module cma_mean #(
    parameter int DEPTH = cma_pkg::DEPTH_DEFAULT,
    parameter int SUM_W = cma_pkg::SAMPLE_BITS + $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cma_pkg::event_kind_t             in_kind,
    input  logic [SUM_W-1:0]                 in_sum,
    input  logic [cma_pkg::OFFSET_BITS-1:0]  full_offset,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cma_pkg::event_kind_t             out_kind,
    output logic [cma_pkg::AVG_BITS-1:0]     average,
    output logic [cma_pkg::AVG_BITS-1:0]     landed_level,
    output logic [cma_pkg::FULL_BITS-1:0]    full_level
);

    localparam int XW    = SUM_W + 1;
    localparam int SHIFT = XW + $clog2(DEPTH);
    localparam int MW    = XW + 1;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;
    localparam int PRODW = XW + MW;

    logic [XW-1:0]                  rounded;
    logic [PRODW-1:0]               product;
    logic [cma_pkg::AVG_BITS-1:0]   mean;
    logic [cma_pkg::FULL_BITS-1:0]  full_diff;
    logic                           accept;
    logic                           valid_reg;
    cma_pkg::event_kind_t           kind_reg;
    logic [cma_pkg::AVG_BITS-1:0]   avg_reg;
    logic [cma_pkg::AVG_BITS-1:0]   landed_reg;
    logic [cma_pkg::FULL_BITS-1:0]  full_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // half up rounding, then divide by depth through the reciprocal
    assign rounded   = XW'(in_sum) + XW'(DEPTH / 2);
    assign product   = PRODW'(rounded) * PRODW'(MW'(RECIP));
    assign mean      = product[SHIFT +: cma_pkg::AVG_BITS];
    assign full_diff = cma_pkg::FULL_BITS'(mean) - cma_pkg::FULL_BITS'(full_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_kind;
            avg_reg  <= mean;
            if (in_kind == cma_pkg::KIND_CALIBRATED)
            begin
                landed_reg <= mean;
                full_reg   <= full_diff;
            end
            else
            begin
                landed_reg <= '0;
                full_reg   <= '0;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign average      = avg_reg;
    assign landed_level = landed_reg;
    assign full_level   = full_reg;

endmodule

@@ tb/sv/cma_checker.sv @@
`timescale 1ns / 1ps
// checker for the calibrating moving average: predicts and compares results
module cma_checker #(
    parameter int DEPTH = cma_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [cma_pkg::S_DATA_BITS-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [cma_pkg::M_DATA_BITS-1:0]  m_tdata,
    input  logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [cma_pkg::OFFSET_BITS-1:0]  cfg_data,
    input  logic                             drained,
    output int                               fail_count,
    output int                               pending,
    output int                               sample_count,
    output int                               result_count
);

    localparam int SAMPLE_W     = cma_pkg::SAMPLE_BITS;
    localparam int AVG_W        = cma_pkg::AVG_BITS;
    localparam int FULL_W       = cma_pkg::FULL_BITS;
    localparam int OFFSET_W     = cma_pkg::OFFSET_BITS;
    localparam int LANDED_LSB   = AVG_W;
    localparam int FULL_LSB     = 2 * AVG_W;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        cma_pkg::event_kind_t   kind;
        logic [AVG_W-1:0]       average;
        logic [AVG_W-1:0]       landed;
        logic [FULL_W-1:0]      full;
    } level_event_t;

    logic [SAMPLE_W-1:0]    window [DEPTH];
    int                     window_pos;
    int                     window_sum;
    int                     samples_taken;
    bit                     calibrated;
    logic [AVG_W-1:0]       landed_level;
    logic [OFFSET_W-1:0]    full_offset;
    level_event_t           expected_events [$];
    bit                     leftovers_checked;

    task automatic report(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%0t ns  %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            report($sformatf("result %0d: %s expected %0d got %0d", result_count, name, want, got));
    endtask

    function automatic int rounded_mean(input int total);
        return (2 * total + DEPTH) / 2 / DEPTH;
    endfunction

    function automatic void clear_model();
        foreach (window[i])
            window[i] = '0;
        window_pos        = 0;
        window_sum        = 0;
        samples_taken     = 0;
        calibrated        = 1'b0;
        landed_level      = '0;
        full_offset       = '0;
        leftovers_checked = 1'b0;
        expected_events.delete();
    endfunction

    function automatic void absorb_sample(input logic [SAMPLE_W-1:0] value);
        level_event_t ev;
        window_sum         = window_sum - int'(window[window_pos]) + int'(value);
        window[window_pos] = value;
        window_pos         = (window_pos + 1) % DEPTH;
        if (calibrated)
        begin
            ev.kind    = cma_pkg::KIND_AVERAGE;
            ev.average = AVG_W'(rounded_mean(window_sum));
            ev.landed  = '0;
            ev.full    = '0;
            expected_events.push_back(ev);
            return;
        end
        samples_taken++;
        if (samples_taken < DEPTH)
            return;
        calibrated   = 1'b1;
        landed_level = AVG_W'(rounded_mean(window_sum));
        ev.kind      = cma_pkg::KIND_CALIBRATED;
        ev.average   = landed_level;
        ev.landed    = landed_level;
        // wraps negative when the offset exceeds the landed level
        ev.full      = {1'b0, landed_level} - {1'b0, full_offset};
        expected_events.push_back(ev);
    endfunction

    task automatic compare_result();
        level_event_t want;
        result_count++;
        if (expected_events.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected, tdata %h",
                             result_count, m_tdata));
            return;
        end
        want = expected_events.pop_front();
        check_field("event_kind", int'(want.kind), int'(m_tuser[0]));
        check_field("average", int'(want.average), int'(m_tdata[AVG_W-1:0]));
        check_field("landed_level", int'(want.landed),
                    int'(m_tdata[LANDED_LSB +: AVG_W]));
        check_field("full_level", int'(want.full), int'(m_tdata[FULL_LSB +: FULL_W]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            fail_count   = 0;
            sample_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                full_offset = cfg_data;
            if (s_tvalid && s_tready)
            begin
                sample_count++;
                absorb_sample(s_tdata[SAMPLE_W-1:0]);
            end
            if (m_tvalid && m_tready)
                compare_result();
            if (drained && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_events.size() != 0)
                    report($sformatf("%0d expected results never arrived",
                                     expected_events.size()));
            end
        end
        pending = expected_events.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, sample and offset stimulus, output stalls and the verdict
module tb;

    localparam int DEPTH         = cma_pkg::DEPTH_DEFAULT;
    localparam int SAMPLE_W      = cma_pkg::SAMPLE_BITS;
    localparam int OFFSET_W      = cma_pkg::OFFSET_BITS;
    localparam int S_DATA_W      = cma_pkg::S_DATA_BITS;
    localparam int M_DATA_W      = cma_pkg::M_DATA_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 288;
    localparam int MODE_SPAN     = 32;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    typedef enum int
    {
        SRC_UNIFORM,
        SRC_EXTREMES,
        SRC_STEADY,
        SRC_NEAR_LEVEL
    } sample_source_t;

    typedef enum int
    {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_LONG_HOLDS
    } ready_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [OFFSET_W-1:0]    cfg_data  = '0;
    logic                   drained   = 1'b0;

    int fail_count;
    int pending;
    int sample_count;
    int result_count;
    int burst_left    = 0;
    int offset_writes = 0;

    calibrating_moving_average_core #(
        .DEPTH      (DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),      // sample[11:0], zero pad
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),      // average, landed_level, full_level, pad
        .m_tuser    (m_tuser),      // event_kind
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)      // full_offset
    );

    cma_checker #(
        .DEPTH          (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .drained        (drained),
        .fail_count     (fail_count),
        .pending        (pending),
        .sample_count   (sample_count),
        .result_count   (result_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tdata  <= {{(S_DATA_W - SAMPLE_W){1'b0}}, value};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // the block may still hold samples that give no result, so wait for pending results, then settle
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        offset_writes++;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_source_t src,
                                                       input logic [SAMPLE_W-1:0] level);
        int v;
        case (src)
            SRC_UNIFORM:
                v = $urandom_range(SAMPLE_MAX, 0);
            SRC_EXTREMES:
                v = ($urandom_range(1, 0) != 0) ? SAMPLE_MAX - $urandom_range(1, 0)
                                                : $urandom_range(1, 0);
            SRC_STEADY:
                v = int'(level);
            default:
            begin
                v = int'(level) + $urandom_range(6, 0) - 3;
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    initial
    begin : output_stalls
        ready_mode_t mode;
        int          span;
        @(posedge rst_n);
        forever
        begin
            mode = ready_mode_t'($urandom_range(3, 0));
            span = $urandom_range(200, 20);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS:
                        m_tready <= 1'b1;
                    READY_MOSTLY:
                        m_tready <= ($urandom_range(3, 0) != 0);
                    READY_RARELY:
                        m_tready <= ($urandom_range(3, 0) == 0);
                    default:
                        m_tready <= ($urandom_range(15, 0) == 0) ? !m_tready : m_tready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0]    cal_samples [16];
        sample_source_t         src;
        logic [SAMPLE_W-1:0]    level;
        logic [OFFSET_W-1:0]    phase_offset;

        cal_samples = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'hAAA,
                        12'h555, 12'h7FF, 12'hFFE, 12'h000, 12'h003,
                        12'h000, 12'h010, 12'h000, 12'h002, 12'h000, 12'h001};
        src   = SRC_UNIFORM;
        level = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // calibration in three groups with offset writes in between
        write_offset('0);
        for (int i = 0; i < 5; i++)
            send_sample(cal_samples[i]);
        wait_idle();
        write_offset(OFFSET_W'($urandom));
        for (int i = 5; i < 10; i++)
            send_sample(cal_samples[i]);
        wait_idle();
        // offset above the landed level, full level wraps negative
        write_offset('1);
        for (int i = 10; i < DEPTH; i++)
            send_sample(cal_samples[i]);
        send_sample('1);
        send_sample('1);
        send_sample('0);
        send_sample('0);

        // offset writes after calibration must not change any result
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       phase_offset = '0;
                1:       phase_offset = '1;
                default: phase_offset = OFFSET_W'($urandom);
            endcase
            write_offset(phase_offset);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % MODE_SPAN == 0)
                begin
                    src   = sample_source_t'($urandom_range(3, 0));
                    level = ($urandom_range(3, 0) == 0)
                          ? SAMPLE_W'($urandom_range(1, 0) * SAMPLE_MAX)
                          : SAMPLE_W'($urandom);
                end
                send_sample(draw_sample(src, level));
            end
        end

        wait_idle();
        drained <= 1'b1;
        repeat (2) @(negedge clk);
        $display("run covered %0d samples, %0d results, %0d offset writes",
                 sample_count, result_count, offset_writes);
        $display("calibration with a wrapped full level, then steady, extreme and noisy levels");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
